@@ design/vpu_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Verlet particle update block.
package vpu_pkg;

  localparam int PARTICLES = 1024;
  localparam int WORD_BITS = 32;
  localparam int SAT_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 31;
  localparam int IDX_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int NP_W      = 48;
  localparam int N_W       = 50;
  localparam int MOD_BITS  = N_W - 1;
  localparam int TAG_W     = NP_W + 32 + REG_W;

  localparam logic OP_DRIFT = 1'b0;
  localparam logic OP_KICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOX_Z   = 3'd2,
    REG_DT      = 3'd3,
    REG_K       = 3'd4,
    REG_WALL_H  = 3'd5,
    REG_WALL_EN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic vld;
    logic op;
    logic wall_on;
    logic periodic;
  } ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return hi[31:0];
    if (x < lo) return lo[31:0];
    return x[31:0];
  endfunction

endpackage

@@ design/vpu_ram.sv @@
// Generic simple dual-port RAM with registered read.
module vpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ design/vpu_mod_pipe.sv @@
// Pipelined floor-modulo unit, one dividend bit per stage, with a tag carried alongside.
module vpu_mod_pipe #(
  parameter int TAG_W = vpu_pkg::TAG_W
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vpu_pkg::MOD_BITS-1:0]  in_m,
  input  logic                          in_neg,
  input  logic [31:0]                   in_d,
  input  logic [TAG_W-1:0]              in_tag,
  output logic [31:0]                   out_r,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int NB = vpu_pkg::MOD_BITS;

  logic [31:0]      rem_r [NB];
  logic [NB-1:0]    m_r   [NB];
  logic             neg_r [NB];
  logic [31:0]      d_r   [NB];
  logic [TAG_W-1:0] tag_r [NB];

  for (genvar j = 0; j < NB; j++) begin : g_stage
    logic [31:0]      rem_in;
    logic [NB-1:0]    m_in;
    logic             neg_in;
    logic [31:0]      d_in;
    logic [TAG_W-1:0] tag_in;
    logic [32:0]      t;
    logic [31:0]      rem_nxt;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign m_in   = in_m;
      assign neg_in = in_neg;
      assign d_in   = in_d;
      assign tag_in = in_tag;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign m_in   = m_r[j-1];
      assign neg_in = neg_r[j-1];
      assign d_in   = d_r[j-1];
      assign tag_in = tag_r[j-1];
    end

    always_comb begin
      t = {rem_in, m_in[NB-1-j]};
      if (t >= {1'b0, d_in}) begin
        rem_nxt = 32'(t - {1'b0, d_in});
      end else begin
        rem_nxt = t[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        m_r[j]   <= m_in;
        neg_r[j] <= neg_in;
        d_r[j]   <= d_in;
        tag_r[j] <= tag_in;
      end
    end
  end

  // negative dividends were inverted on entry: floor mod is d-1-rem
  assign out_r   = neg_r[NB-1] ? (d_r[NB-1] - 32'd1 - rem_r[NB-1]) : rem_r[NB-1];
  assign out_tag = tag_r[NB-1];

endmodule

@@ design/verlet_particle_update.sv @@
// Top level of the Verlet particle update block.
// One particle word is accepted per clock and one result word leaves per clock; each word
// passes through stages s1 to s5, the bit-per-stage modulo pipeline used for periodic
// wrapping and the output register. Old forces live in one RAM written by drift words and
// read by kick words at acceptance, so a kick directly after the drift of the same particle
// sees the new force. The whole pipeline holds while the output word is stalled.
module verlet_particle_update #(
  parameter int PARTICLES = vpu_pkg::PARTICLES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [vpu_pkg::IDX_W-1:0]         in_particle,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic signed [31:0]                in_pos_z,
  input  logic signed [31:0]                in_vel_x,
  input  logic signed [31:0]                in_vel_y,
  input  logic signed [31:0]                in_vel_z,
  input  logic signed [31:0]                in_frc_x,
  input  logic signed [31:0]                in_frc_y,
  input  logic signed [31:0]                in_frc_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_new_pos_x,
  output logic signed [31:0]                out_new_pos_y,
  output logic signed [31:0]                out_new_pos_z,
  output logic signed [31:0]                out_new_vel_x,
  output logic signed [31:0]                out_new_vel_y,
  output logic signed [31:0]                out_new_vel_z,
  input  logic                              cfg_we,
  input  logic [vpu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vpu_pkg::REG_W-1:0]         cfg_data
);

  localparam int AW  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int NB  = vpu_pkg::MOD_BITS;
  localparam int FB  = vpu_pkg::FRAC_BITS;
  localparam int NPW = vpu_pkg::NP_W;
  localparam int NW  = vpu_pkg::N_W;
  localparam int RW  = vpu_pkg::REG_W;
  localparam int TW  = vpu_pkg::TAG_W;

  logic [RW-1:0] box_r [3];
  logic [RW-1:0] dt_r;
  logic [RW-1:0] k_r;
  logic [RW-1:0] wall_half_r;
  logic          wall_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0]    <= '0;
      box_r[1]    <= '0;
      box_r[2]    <= '0;
      dt_r        <= '0;
      k_r         <= '0;
      wall_half_r <= '0;
      wall_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (vpu_pkg::cfg_reg_t'(cfg_index))
        vpu_pkg::REG_BOX_X:   box_r[0]    <= cfg_data;
        vpu_pkg::REG_BOX_Y:   box_r[1]    <= cfg_data;
        vpu_pkg::REG_BOX_Z:   box_r[2]    <= cfg_data;
        vpu_pkg::REG_DT:      dt_r        <= cfg_data;
        vpu_pkg::REG_K:       k_r         <= cfg_data;
        vpu_pkg::REG_WALL_H:  wall_half_r <= cfg_data;
        vpu_pkg::REG_WALL_EN: wall_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic out_valid_r;
  logic en;
  logic acc;
  logic idx_ok;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign acc      = in_valid && en;
  assign idx_ok   = 32'(in_particle) < 32'(PARTICLES);

  // old force store
  logic [95:0] ram_rdata;

  vpu_ram #(
    .WIDTH (96),
    .DEPTH (PARTICLES)
  ) u_force_ram (
    .clk   (clk),
    .we    (acc && (in_op == vpu_pkg::OP_DRIFT) && idx_ok),
    .waddr (AW'(in_particle)),
    .wdata ({in_frc_z, in_frc_y, in_frc_x}),
    .re    (acc && (in_op == vpu_pkg::OP_KICK)),
    .raddr (AW'(in_particle)),
    .rdata (ram_rdata)
  );

  logic signed [31:0] in_pos [3];
  logic signed [31:0] in_vel [3];
  logic signed [31:0] in_frc [3];

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;
  assign in_vel[0] = in_vel_x;
  assign in_vel[1] = in_vel_y;
  assign in_vel[2] = in_vel_z;
  assign in_frc[0] = in_frc_x;
  assign in_frc[1] = in_frc_y;
  assign in_frc[2] = in_frc_z;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_op_r, s2_op_r, s3_op_r, s4_op_r;
  logic s1_ok_r;
  vpu_pkg::ctrl_t s5_ctrl_r;
  vpu_pkg::ctrl_t ctrl_r [NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_ctrl_r <= '0;
      for (int j = 0; j < NB; j++) begin
        ctrl_r[j] <= '0;
      end
    end else if (en) begin
      s1_vld_r           <= acc;
      s2_vld_r           <= s1_vld_r;
      s3_vld_r           <= s2_vld_r;
      s4_vld_r           <= s3_vld_r;
      s5_ctrl_r.vld      <= s4_vld_r;
      s5_ctrl_r.op       <= s4_op_r;
      s5_ctrl_r.wall_on  <= wall_en_r && (wall_half_r != '0);
      s5_ctrl_r.periodic <= (box_r[0] != '0) && (box_r[1] != '0) && (box_r[2] != '0);
      ctrl_r[0]          <= s5_ctrl_r;
      for (int j = 1; j < NB; j++) begin
        ctrl_r[j] <= ctrl_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= in_op;
      s1_ok_r <= idx_ok;
      s2_op_r <= s1_op_r;
      s3_op_r <= s2_op_r;
      s4_op_r <= s3_op_r;
    end
  end

  logic signed [31:0] res_pos [3];
  logic signed [31:0] res_vel [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [31:0] s1_pos_r, s1_vel_r, s1_frc_r;
    logic signed [31:0] s2_pos_r, s2_vel_r;
    logic signed [63:0] s2_p1_r, s2_pv_r;
    logic signed [31:0] s3_pos_r, s3_vel_r;
    logic signed [63:0] s3_p2_r, s3_pv_r;
    logic signed [31:0] s4_pos_r, s4_nv_r;
    logic signed [63:0] s4_p3_r, s4_pv_r;
    logic [NB-1:0]      s5_m_r;
    logic               s5_neg_r;
    logic [31:0]        s5_d_r;
    logic [TW-1:0]      s5_tag_r;

    logic signed [31:0]  f_old;
    logic signed [32:0]  f_sum;
    logic signed [31:0]  a_s3;
    logic signed [31:0]  adt_s4;
    logic signed [31:0]  nv_s4;
    logic signed [63:0]  np;
    logic signed [NPW-1:0] x_s5;
    logic signed [NW-1:0]  n_s5;
    logic [31:0]         mod_r;
    logic [TW-1:0]       mod_tag;
    logic signed [NPW-1:0] t_x;
    logic signed [31:0]  t_nv;
    logic [RW-1:0]       t_box;
    logic signed [32:0]  wdiff;
    logic signed [31:0]  w;
    logic signed [31:0]  pw;
    logic [32:0]         pabs;

    assign f_old = s1_ok_r ? $signed(ram_rdata[k*32 +: 32]) : 32'sd0;

    always_comb begin
      if (s1_op_r == vpu_pkg::OP_DRIFT) begin
        f_sum = 33'(s1_frc_r);
      end else begin
        f_sum = 33'(f_old) + 33'(s1_frc_r);
      end
    end

    assign a_s3   = vpu_pkg::sat32(s2_p1_r >>> FB);
    assign adt_s4 = vpu_pkg::sat32(s3_p2_r >>> FB);
    assign nv_s4  = (s3_op_r == vpu_pkg::OP_DRIFT) ? s3_vel_r
                  : vpu_pkg::sat32(64'(s3_vel_r) + (s3_p2_r >>> (FB + 1)));

    assign np   = 64'(s4_pos_r) + (s4_pv_r >>> FB) + (s4_p3_r >>> (FB + 1));
    assign x_s5 = (s4_op_r == vpu_pkg::OP_DRIFT) ? np[NPW-1:0] : NPW'(s4_pos_r);
    assign n_s5 = (NW'(x_s5) <<< 1) + NW'($signed({1'b0, box_r[k]}));

    always_ff @(posedge clk) begin
      if (en) begin
        s1_pos_r <= in_pos[k];
        s1_vel_r <= in_vel[k];
        s1_frc_r <= in_frc[k];
        s2_pos_r <= s1_pos_r;
        s2_vel_r <= s1_vel_r;
        s2_p1_r  <= $signed({1'b0, k_r}) * f_sum;
        s2_pv_r  <= s1_vel_r * $signed({1'b0, dt_r});
        s3_pos_r <= s2_pos_r;
        s3_vel_r <= s2_vel_r;
        s3_p2_r  <= a_s3 * $signed({1'b0, dt_r});
        s3_pv_r  <= s2_pv_r;
        s4_pos_r <= s3_pos_r;
        s4_nv_r  <= nv_s4;
        s4_p3_r  <= adt_s4 * $signed({1'b0, dt_r});
        s4_pv_r  <= s3_pv_r;
        s5_neg_r <= n_s5[NW-1];
        s5_m_r   <= n_s5[NW-1] ? ~n_s5[NB-1:0] : n_s5[NB-1:0];
        s5_d_r   <= {box_r[k], 1'b0};
        s5_tag_r <= {x_s5, s4_nv_r, box_r[k]};
      end
    end

    vpu_mod_pipe #(
      .TAG_W (TW)
    ) u_mod (
      .clk     (clk),
      .en      (en),
      .in_m    (s5_m_r),
      .in_neg  (s5_neg_r),
      .in_d    (s5_d_r),
      .in_tag  (s5_tag_r),
      .out_r   (mod_r),
      .out_tag (mod_tag)
    );

    assign t_x   = mod_tag[TW-1 -: NPW];
    assign t_nv  = mod_tag[RW +: 32];
    assign t_box = mod_tag[RW-1:0];
    assign wdiff = $signed({1'b0, mod_r}) - $signed({2'b0, t_box});
    assign w     = wdiff[32:1];
    assign pw    = ctrl_r[NB-1].periodic ? w : t_x[31:0];
    assign pabs  = pw[31] ? 33'(-33'(pw)) : 33'(pw);

    always_comb begin
      res_pos[k] = t_x[31:0];
      res_vel[k] = t_nv;
      if (ctrl_r[NB-1].op == vpu_pkg::OP_DRIFT) begin
        res_pos[k] = (t_box == '0) ? vpu_pkg::sat32(64'(t_x)) : w;
      end else if (ctrl_r[NB-1].wall_on && (pabs > {2'b0, wall_half_r})) begin
        if (t_nv == 32'sd0) begin
          res_vel[k] = 32'sd0;
        end else if ((pw > 32'sd0) == (t_nv > 32'sd0)) begin
          res_vel[k] = vpu_pkg::sat32(-64'(t_nv));
        end
      end
    end
  end

  logic signed [31:0] out_pos_r [3];
  logic signed [31:0] out_vel_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctrl_r[NB-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        out_pos_r[k] <= res_pos[k];
        out_vel_r[k] <= res_vel[k];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_pos_x = out_pos_r[0];
  assign out_new_pos_y = out_pos_r[1];
  assign out_new_pos_z = out_pos_r[2];
  assign out_new_vel_x = out_vel_r[0];
  assign out_new_vel_y = out_vel_r[1];
  assign out_new_vel_z = out_vel_r[2];

`ifndef SYNTHESIS
  a_acc_enters: assert property (@(posedge clk) disable iff (!rst_n) acc |=> s1_vld_r)
    else $error("accepted word missing from first stage");
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !en) |=> s1_vld_r)
    else $error("first stage lost a word while stalled");
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
